/* sv/owse_pkg.sv */
// ----------------------------------------------------------------------------
// owse_pkg: shared types and codes for the 1-Wire ROM search core
// Command codes, status codes and search constants.
// ----------------------------------------------------------------------------
package owse_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [2:0] status_t;

  localparam cmd_t CMD_RESET = 2'd0;
  localparam cmd_t CMD_START = 2'd1;
  localparam cmd_t CMD_BIT   = 2'd2;

  localparam status_t ST_RESET_DONE = 3'd0;
  localparam status_t ST_SEND_OP    = 3'd1;
  localparam status_t ST_DIRECTION  = 3'd2;
  localparam status_t ST_FOUND      = 3'd3;
  localparam status_t ST_FAILED     = 3'd4;
  localparam status_t ST_IGNORED    = 3'd5;

  localparam int unsigned ROM_BITS     = 64;
  localparam int unsigned POS_W        = 7;
  localparam int unsigned FAMILY_LIMIT = 9;
  localparam int unsigned FAM_W        = 4;

  localparam logic [7:0] OPCODE_RESET = 8'hF0;

endpackage

/* sv/onewire_rom_search_engine_core.sv */
// ----------------------------------------------------------------------------
// onewire_rom_search_engine_core: 1-Wire Search ROM decision core
// Holds the search memory, picks the direction for each ROM position and
// reports the found ROM code at the end of a pass.
// ----------------------------------------------------------------------------
// One request is taken per clock and its result appears in the result
// register on the next clock. The only limit on rate is the result register:
// a new request is taken whenever that register is empty or is being
// emptied in the same cycle, so with out_ready held high the core sustains
// one request per cycle. Configuration writes of the search opcode take
// effect on the next clock.
module onewire_rom_search_engine_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  owse_pkg::cmd_t       in_command,
  input  logic                 in_no_presence,
  input  logic                 in_id_bit,
  input  logic                 in_cmp_id_bit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output owse_pkg::status_t    out_status,
  output logic                 out_direction_bit,
  output logic [7:0]           out_tx_byte,
  output logic [63:0]          out_rom_code,
  output logic                 out_last_device,
  output logic [3:0]           out_family_discrepancy
);

  localparam int unsigned PW = owse_pkg::POS_W;
  localparam int unsigned FW = owse_pkg::FAM_W;

  logic [7:0]    opcode_r;
  logic [63:0]   rom_r, rom_nxt;
  logic [PW-1:0] ld_r, ld_nxt;
  logic          ldev_r, ldev_nxt;
  logic [FW-1:0] fam_r, fam_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] lz_r, lz_nxt;
  logic          pass_r, pass_nxt;

  owse_pkg::status_t status_nxt;
  logic              dir_nxt;
  logic [7:0]        tx_nxt;

  logic          out_valid_r;
  owse_pkg::status_t out_status_r;
  logic          out_dir_r;
  logic [7:0]    out_tx_r;
  logic [63:0]   out_rom_r;
  logic          out_ldev_r;
  logic [FW-1:0] out_fam_r;

  logic          accept;
  logic [PW-1:0] pos;
  logic [5:0]    shift;
  logic          dir;
  logic [PW-1:0] lz_b;
  logic [FW-1:0] fam_b;
  logic [63:0]   rom_b;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos = pos_r;
    if (pos_r < PW'(1) || pos_r > PW'(owse_pkg::ROM_BITS)) begin
      pos = PW'(1);
    end
    shift = 6'(pos - PW'(1));
    lz_b  = lz_r;
    fam_b = fam_r;
    if (in_id_bit != in_cmp_id_bit) begin
      dir = in_id_bit;
    end else begin
      if (pos < ld_r) begin
        dir = rom_r[shift];
      end else begin
        dir = (pos == ld_r);
      end
      if (!dir) begin
        lz_b = pos;
        if (pos < PW'(owse_pkg::FAMILY_LIMIT)) begin
          fam_b = FW'(pos);
        end
      end
    end
    rom_b        = rom_r;
    rom_b[shift] = dir;
  end

  always_comb begin
    rom_nxt    = rom_r;
    ld_nxt     = ld_r;
    ldev_nxt   = ldev_r;
    fam_nxt    = fam_r;
    pos_nxt    = pos_r;
    lz_nxt     = lz_r;
    pass_nxt   = pass_r;
    status_nxt = owse_pkg::ST_IGNORED;
    dir_nxt    = 1'b0;
    tx_nxt     = 8'd0;
    unique case (in_command)
      owse_pkg::CMD_RESET: begin
        ld_nxt     = '0;
        ldev_nxt   = 1'b0;
        fam_nxt    = '0;
        pass_nxt   = 1'b0;
        pos_nxt    = PW'(1);
        lz_nxt     = '0;
        status_nxt = owse_pkg::ST_RESET_DONE;
      end
      owse_pkg::CMD_START: begin
        if (ldev_r || in_no_presence) begin
          ld_nxt     = '0;
          ldev_nxt   = 1'b0;
          fam_nxt    = '0;
          pass_nxt   = 1'b0;
          pos_nxt    = PW'(1);
          lz_nxt     = '0;
          status_nxt = owse_pkg::ST_FAILED;
        end else begin
          pass_nxt   = 1'b1;
          pos_nxt    = PW'(1);
          lz_nxt     = '0;
          status_nxt = owse_pkg::ST_SEND_OP;
          tx_nxt     = opcode_r;
        end
      end
      owse_pkg::CMD_BIT: begin
        if (pass_r) begin
          if (in_id_bit && in_cmp_id_bit) begin
            ld_nxt     = '0;
            ldev_nxt   = 1'b0;
            fam_nxt    = '0;
            pass_nxt   = 1'b0;
            pos_nxt    = PW'(1);
            lz_nxt     = '0;
            status_nxt = owse_pkg::ST_FAILED;
          end else begin
            rom_nxt = rom_b;
            fam_nxt = fam_b;
            dir_nxt = dir;
            if (pos == PW'(owse_pkg::ROM_BITS)) begin
              ld_nxt   = lz_b;
              ldev_nxt = ldev_r || (lz_b == '0);
              pass_nxt = 1'b0;
              pos_nxt  = PW'(1);
              lz_nxt   = '0;
              if (rom_b[7:0] == 8'd0) begin
                ld_nxt     = '0;
                ldev_nxt   = 1'b0;
                fam_nxt    = '0;
                status_nxt = owse_pkg::ST_FAILED;
              end else begin
                status_nxt = owse_pkg::ST_FOUND;
              end
            end else begin
              lz_nxt     = lz_b;
              pos_nxt    = pos + PW'(1);
              status_nxt = owse_pkg::ST_DIRECTION;
            end
          end
        end
      end
      default: begin
        status_nxt = owse_pkg::ST_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opcode_r    <= owse_pkg::OPCODE_RESET;
      rom_r       <= '0;
      ld_r        <= '0;
      ldev_r      <= 1'b0;
      fam_r       <= '0;
      pos_r       <= PW'(1);
      lz_r        <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        opcode_r <= cfg_wr_data;
      end
      if (accept) begin
        rom_r  <= rom_nxt;
        ld_r   <= ld_nxt;
        ldev_r <= ldev_nxt;
        fam_r  <= fam_nxt;
        pos_r  <= pos_nxt;
        lz_r   <= lz_nxt;
        pass_r <= pass_nxt;
      end
      if (in_ready) begin
        out_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_dir_r    <= dir_nxt;
      out_tx_r     <= tx_nxt;
      out_rom_r    <= rom_nxt;
      out_ldev_r   <= ldev_nxt;
      out_fam_r    <= fam_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_direction_bit      = out_dir_r;
  assign out_tx_byte            = out_tx_r;
  assign out_rom_code           = out_rom_r;
  assign out_last_device        = out_ldev_r;
  assign out_family_discrepancy = out_fam_r;

endmodule

/* sv/owse_checker.sv */
// ----------------------------------------------------------------------------
// owse_checker: port-level checks for the 1-Wire ROM search core
// Watches the result channel and the reported search state.
// ----------------------------------------------------------------------------
module owse_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input owse_pkg::status_t out_status,
  input logic              out_direction_bit,
  input logic [7:0]        out_tx_byte,
  input logic              out_last_device,
  input logic [3:0]        out_family_discrepancy
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("stalled result dropped or changed");

  a_tx_only_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != owse_pkg::ST_SEND_OP |-> out_tx_byte == 8'd0)
    else $error("opcode byte outside send request");

  a_dir_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == owse_pkg::ST_RESET_DONE ||
                  out_status == owse_pkg::ST_SEND_OP ||
                  out_status == owse_pkg::ST_IGNORED) |-> !out_direction_bit)
    else $error("direction bit set without a bit request");

  a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == owse_pkg::ST_FAILED |->
      !out_last_device && out_family_discrepancy == 4'd0)
    else $error("search memory not cleared on failure");

endmodule

bind onewire_rom_search_engine_core owse_checker u_owse_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_status             (out_status),
  .out_direction_bit      (out_direction_bit),
  .out_tx_byte            (out_tx_byte),
  .out_last_device        (out_last_device),
  .out_family_discrepancy (out_family_discrepancy)
);
